// ===== rtl/core/stsk_pkg.sv =====
// shared types for the stirling number block
`timescale 1ns / 1ps
`default_nettype none

package stsk_pkg;

  localparam int unsigned ValW = 64;

  typedef struct packed {
    logic [9:0] n_value;
    logic [5:0] k_value;
  } stsk_in_t;

  typedef struct packed {
    logic [ValW-1:0] stirling_value;
    logic            saturated;
  } stsk_out_t;

  // one step command, shared by every cell in the chain
  typedef struct packed {
    logic clear;
    logic mul;
    logic add;
    logic shift;
  } stsk_cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/stirling_second_kind_dp.sv =====
// top level: stirling numbers of the second kind on a chain of multiply-add cells
//
//   port group | dir | handshake              | word
//   in         | in  | in_valid_i/in_ready_o  | stsk_in_t  (n_value, k_value)
//   out        | out | out_valid_o/out_ready_i| stsk_out_t (stirling_value, saturated)
//
// an in-range query runs a clear step, then for each row a multiply step and an
// add step across all cells at once, then k shifts bring entry k down to entry 0.
// out-of-range queries skip the cells and answer all ones with the flag set.
// reset clears the control state; the cells are cleared at the start of each
// in-range query. a new query is taken once the previous one has been handed to
// the output register; a stalled result holds in that register.
`timescale 1ns / 1ps
`default_nettype none

module stirling_second_kind_dp #(
  parameter int unsigned K_MAX = 63,
  parameter int unsigned N_MAX = 1023
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire stsk_pkg::stsk_in_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output stsk_pkg::stsk_out_t       out_data_o
);

  localparam int unsigned VW = stsk_pkg::ValW;
  localparam int unsigned JW = (K_MAX < 2) ? 1 : $clog2(K_MAX + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CLEAR = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_ADD   = 6'b001000,
    ST_SHIFT = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e    state_q, state_d;
  logic [9:0] rows_q, rows_d;
  logic [5:0] shift_q, shift_d;
  logic       err_q, err_d;
  logic       out_valid_q, out_valid_d;
  stsk_pkg::stsk_out_t out_q, out_d;
  logic [VW-1:0] row0_q, row0_d;
  logic          sat0_q, sat0_d;

  stsk_pkg::stsk_cell_ctrl_t ctrl;
  logic [VW-1:0] val_w [0:K_MAX+1];
  logic          sat_w [0:K_MAX+1];

  logic in_fire, range_err, out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign range_err  = (32'(in_data_i.k_value) > K_MAX) || (32'(in_data_i.n_value) > N_MAX);
  assign out_free   = ~out_valid_q | out_ready_i;

  assign val_w[0]       = row0_q;
  assign sat_w[0]       = sat0_q;
  assign val_w[K_MAX+1] = '0;
  assign sat_w[K_MAX+1] = 1'b0;

  for (genvar j = 1; j <= K_MAX; j++) begin : g_cell
    stsk_cell #(
      .J  (j),
      .JW (JW)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .left_val_i  (val_w[j-1]),
      .left_sat_i  (sat_w[j-1]),
      .right_val_i (val_w[j+1]),
      .right_sat_i (sat_w[j+1]),
      .val_o       (val_w[j]),
      .sat_o       (sat_w[j])
    );
  end

  always_comb begin
    state_d     = state_q;
    rows_d      = rows_q;
    shift_d     = shift_q;
    err_d       = err_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    row0_d      = row0_q;
    sat0_d      = sat0_q;
    ctrl        = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          rows_d  = in_data_i.n_value;
          shift_d = in_data_i.k_value;
          err_d   = range_err;
          state_d = range_err ? ST_DONE : ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        ctrl.clear = 1'b1;
        row0_d     = VW'(1);
        sat0_d     = 1'b0;
        state_d    = (rows_q == '0) ? ST_SHIFT : ST_MUL;
      end
      ST_MUL: begin
        ctrl.mul = 1'b1;
        state_d  = ST_ADD;
      end
      ST_ADD: begin
        ctrl.add = 1'b1;
        row0_d   = '0;
        sat0_d   = 1'b0;
        rows_d   = rows_q - 10'd1;
        state_d  = (rows_q == 10'd1) ? ST_SHIFT : ST_MUL;
      end
      ST_SHIFT: begin
        // walk entry k down to entry 0
        if (shift_q == '0) begin
          state_d = ST_DONE;
        end else begin
          ctrl.shift = 1'b1;
          row0_d     = val_w[1];
          sat0_d     = sat_w[1];
          shift_d    = shift_q - 6'd1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (err_q) begin
            out_d.stirling_value = {VW{1'b1}};
            out_d.saturated      = 1'b1;
          end else begin
            out_d.stirling_value = row0_q;
            out_d.saturated      = sat0_q;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rows_q      <= '0;
      shift_q     <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rows_q      <= rows_d;
      shift_q     <= shift_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    row0_q <= row0_d;
    sat0_q <= sat0_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/stsk_cell.sv =====
// one row entry: saturating j*row[j] + row[j-1] over a multiply step and an add step, plus shift-down path
`timescale 1ns / 1ps
`default_nettype none

module stsk_cell #(
  parameter int unsigned J  = 1,
  parameter int unsigned JW = 6
) (
  input  wire logic                       clk_i,
  input  wire stsk_pkg::stsk_cell_ctrl_t  ctrl_i,
  input  wire logic [stsk_pkg::ValW-1:0]  left_val_i,
  input  wire logic                       left_sat_i,
  input  wire logic [stsk_pkg::ValW-1:0]  right_val_i,
  input  wire logic                       right_sat_i,
  output logic      [stsk_pkg::ValW-1:0]  val_o,
  output logic                            sat_o
);

  localparam int unsigned VW = stsk_pkg::ValW;
  localparam logic [JW-1:0] JC = JW'(J);

  logic [VW-1:0]    val_q, val_d;
  logic             sat_q, sat_d;
  logic [VW-1:0]    prod_q;
  logic             povf_q;
  logic [VW+JW-1:0] prod;
  logic [VW:0]      sum;
  logic             ovf;

  assign prod = {{JW{1'b0}}, val_q} * {{VW{1'b0}}, JC};
  assign sum  = {1'b0, prod_q} + {1'b0, left_val_i};
  assign ovf  = povf_q | sum[VW] | left_sat_i;

  always_comb begin
    val_d = val_q;
    sat_d = sat_q;
    if (ctrl_i.clear) begin
      val_d = '0;
      sat_d = 1'b0;
    end else if (ctrl_i.add) begin
      val_d = ovf ? {VW{1'b1}} : sum[VW-1:0];
      sat_d = ovf;
    end else if (ctrl_i.shift) begin
      val_d = right_val_i;
      sat_d = right_sat_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    sat_q <= sat_d;
    if (ctrl_i.mul) begin
      prod_q <= prod[VW-1:0];
      povf_q <= (|prod[VW+JW-1:VW]) | sat_q;
    end
  end

  assign val_o = val_q;
  assign sat_o = sat_q;

endmodule

`default_nettype wire

// ===== rtl/core/stsk_checker.sv =====
// port-level checks for the stirling number block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module stsk_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire stsk_pkg::stsk_in_t  in_data_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire stsk_pkg::stsk_out_t out_data_o
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // a taken query makes the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("block still ready right after taking a query");

  // a saturated word always reads all ones
  a_sat_all_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |-> (&out_data_o.stirling_value))
    else $error("saturated word is not all ones");

  // a new result only comes out of a busy block
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a query in flight");

endmodule

bind stirling_second_kind_dp stsk_checker u_stsk_checker (.*);

`default_nettype wire

// ===== tb/sv/stirling_second_kind_dp_tb.sv =====
// testbench for the stirling number block: directed table, random queries, row-walk predictor
`timescale 1ns / 1ps

module stirling_second_kind_dp_tb;

  localparam int unsigned KMax       = 63;
  localparam int unsigned NMax       = 1023;
  localparam int unsigned IdlePct    = 12;
  localparam int unsigned RandQueries = 100;
  localparam int unsigned StallLimit = 20000;
  localparam logic [63:0] AllOnes    = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [9:0]  n;
    logic [5:0]  k;
    bit          typed;
    logic [63:0] value;
    logic        sat;
  } query_row_t;

  // rows without a typed answer go through the predictor
  query_row_t directed_rows [0:20] = '{
    '{10'd0,    6'd0,  1'b1, 64'd1,                  1'b0},
    '{10'd7,    6'd0,  1'b1, 64'd0,                  1'b0},
    '{10'd0,    6'd63, 1'b1, 64'd0,                  1'b0},
    '{10'd1,    6'd1,  1'b1, 64'd1,                  1'b0},
    '{10'd1023, 6'd0,  1'b1, 64'd0,                  1'b0},
    '{10'd1023, 6'd1,  1'b1, 64'd1,                  1'b0},
    '{10'd63,   6'd63, 1'b1, 64'd1,                  1'b0},
    '{10'd1023, 6'd63, 1'b1, AllOnes,                1'b1},
    '{10'd64,   6'd2,  1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0},
    // exactly fits: all ones without the flag
    '{10'd65,   6'd2,  1'b1, AllOnes,                1'b0},
    '{10'd66,   6'd2,  1'b1, AllOnes,                1'b1},
    '{10'd10,   6'd2,  1'b1, 64'd511,                1'b0},
    '{10'd5,    6'd6,  1'b1, 64'd0,                  1'b0},
    '{10'd62,   6'd63, 1'b1, 64'd0,                  1'b0},
    '{10'd1,    6'd0,  1'b1, 64'd0,                  1'b0},
    '{10'd7,    6'd3,  1'b0, 64'd0,                  1'b0},
    '{10'd63,   6'd62, 1'b0, 64'd0,                  1'b0},
    '{10'd30,   6'd15, 1'b0, 64'd0,                  1'b0},
    '{10'd512,  6'd32, 1'b0, 64'd0,                  1'b0},
    '{10'd100,  6'd40, 1'b0, 64'd0,                  1'b0},
    '{10'd27,   6'd21, 1'b0, 64'd0,                  1'b0}
  };

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  stsk_pkg::stsk_in_t  in_data = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  stsk_pkg::stsk_out_t out_data;

  stsk_pkg::stsk_out_t pending_stirling [$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  bit          steady_phase = 1'b0;

  stirling_second_kind_dp #(
    .K_MAX(KMax),
    .N_MAX(NMax)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // walks the saturating rows up to n, with a sticky overflow bit per entry
  function automatic stsk_pkg::stsk_out_t calc_stirling(input logic [9:0] n,
                                                        input logic [5:0] k);
    logic [63:0]  row [0:KMax];
    logic         row_sat [0:KMax];
    logic [127:0] prod;
    logic [64:0]  sum;
    logic         ovf;
    int           nn;
    int           kk;
    int           top;
    stsk_pkg::stsk_out_t res;
    nn = int'(n);
    kk = int'(k);
    if (kk > int'(KMax) || nn > int'(NMax)) begin
      res.stirling_value = AllOnes;
      res.saturated = 1'b1;
      return res;
    end
    for (int j = 0; j <= int'(KMax); j++) begin
      row[j] = '0;
      row_sat[j] = 1'b0;
    end
    row[0] = 64'd1;
    for (int i = 1; i <= nn; i++) begin
      top = (i < kk) ? i : kk;
      for (int j = top; j > 0; j--) begin
        ovf = row_sat[j] | row_sat[j-1];
        prod = 128'(row[j]) * 128'(j);
        if (prod[127:64] != '0) ovf = 1'b1;
        sum = 65'(prod[63:0]) + 65'(row[j-1]);
        if (sum[64]) ovf = 1'b1;
        row[j] = ovf ? AllOnes : sum[63:0];
        row_sat[j] = ovf;
      end
      row[0] = '0;
      row_sat[0] = 1'b0;
    end
    res.stirling_value = row[kk];
    res.saturated = row_sat[kk];
    return res;
  endfunction

  task automatic send_query(input stsk_pkg::stsk_in_t q, input stsk_pkg::stsk_out_t want);
    while (!steady_phase && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= q;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    pending_stirling.push_back(want);
  endtask

  always @(posedge clk_i) begin
    out_ready <= rst_ni && (steady_phase || $urandom_range(99) >= IdlePct);
  end

  stsk_pkg::stsk_out_t want_word;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (pending_stirling.size() == 0) begin
        $error("unexpected word: stirling_value %0d saturated %0d",
               out_data.stirling_value, out_data.saturated);
        mismatch_count++;
      end else begin
        want_word = pending_stirling.pop_front();
        if (out_data.stirling_value !== want_word.stirling_value) begin
          $error("stirling_value: expected %0d, got %0d",
                 want_word.stirling_value, out_data.stirling_value);
          mismatch_count++;
        end
        if (out_data.saturated !== want_word.saturated) begin
          $error("saturated: expected %0d, got %0d",
                 want_word.saturated, out_data.saturated);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    stsk_pkg::stsk_in_t  q;
    stsk_pkg::stsk_out_t want;
    int unsigned sel;
    int unsigned nv;
    int unsigned kv;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      q.n_value = directed_rows[r].n;
      q.k_value = directed_rows[r].k;
      if (directed_rows[r].typed) begin
        want.stirling_value = directed_rows[r].value;
        want.saturated = directed_rows[r].sat;
      end else begin
        want = calc_stirling(q.n_value, q.k_value);
      end
      send_query(q, want);
    end

    for (int unsigned it = 0; it < RandQueries; it++) begin
      steady_phase = (it >= 40 && it < 70);
      sel = $urandom_range(99);
      if (sel < 50) begin
        nv = $urandom_range(40);
        kv = $urandom_range(nv + 1);
      end else if (sel < 65) begin
        // around the point where small k runs out of 64 bits
        nv = $urandom_range(90, 55);
        kv = $urandom_range(6, 1);
      end else if (sel < 80) begin
        nv = $urandom_range(80);
        kv = $urandom_range(63);
      end else if (sel < 95) begin
        nv = $urandom_range(200, 41);
        kv = $urandom_range(63);
      end else begin
        nv = $urandom_range(1023);
        kv = $urandom_range(63);
      end
      q.n_value = 10'(nv);
      q.k_value = 6'(kv);
      send_query(q, calc_stirling(q.n_value, q.k_value));
    end
    steady_phase = 1'b0;
    in_valid <= 1'b0;

    while (pending_stirling.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatch_count == 0 && pending_stirling.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
